[rtl/mme_pkg.sv]
// Shared types and codes for the matrix multiply engine.
// No dependencies; compile first.
package mme_pkg;

	localparam int CMD_W      = 2;
	localparam int ROW_W      = 3;
	localparam int PROD_W     = 32;
	localparam int ACC_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// input item commands
	localparam logic [CMD_W-1:0] CMD_LOAD_A   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

	// controller to datapath
	typedef struct packed {
		logic             ld_a;
		logic             ld_b;
		logic             rd_en;
		logic             first;
		logic             last_k;
		logic             emit;
		logic             emit_err;
		logic             emit_last;
		logic [ROW_W-1:0] emit_row;
		logic [ROW_W-1:0] emit_col;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sum_done;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/mme_if.sv]
// Input and result channel interfaces of the matrix multiply engine.
// Depends on mme_pkg.
interface mme_in_if import mme_pkg::*; #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic [CMD_W-1:0]             command;
	logic [ROW_W-1:0]             row;
	logic [ROW_W-1:0]             col;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, command, row, col, value, input ready);
	modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface mme_out_if import mme_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [PROD_W-1:0] product;
	logic [ROW_W-1:0]         out_row;
	logic [ROW_W-1:0]         out_col;
	logic                     last;
	logic                     dim_error;

	modport source (output valid, product, out_row, out_col, last, dim_error, input ready);
	modport sink   (input valid, product, out_row, out_col, last, dim_error, output ready);
endinterface

[rtl/matrix_multiply_engine.sv]
// Top level of the matrix multiply engine: controller plus datapath.
// Depends on mme_pkg, mme_if, mme_controller, mme_datapath.
//
//  channel  dir  handshake          payload
//  cfg      in   cfg_we             cfg_index, cfg_data (4-bit dimension)
//  in_ch    in   valid/ready        command, row, col, value
//  out_ch   out  valid/ready        product, out_row, out_col, last, dim_error
//
// A load item is written to its store in its accept cycle. A multiply item takes
// (clamped dimensions) the accept cycle, then per product element (a_rows*b_cols
// of them) a_cols store reads into the multiply-accumulate pipeline, then drain and
// hand-off to the result register. A dimension error hands a zero error result on.
// arst_n clears control state only; the stores hold garbage until loaded.
// A stalled result register holds the walk at the next element's hand-off.
module matrix_multiply_engine import mme_pkg::*; #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mme_in_if.sink                in_ch,
	mme_out_if.source             out_ch
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

	mme_controller #(
		.MAX_DIM (MAX_DIM),
		.ADDR_W  (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_command (in_ch.command),
		.in_row     (in_ch.row),
		.in_col     (in_ch.col),
		.cmd        (cmd),
		.stat       (stat),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b)
	);

	mme_datapath #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.ld_row    (in_ch.row),
		.ld_col    (in_ch.col),
		.ld_value  (in_ch.value),
		.out_ch    (out_ch)
	);

endmodule

[rtl/mme_datapath.sv]
// Datapath: element stores, read/multiply/accumulate pipeline, result register.
// Depends on mme_pkg and mme_out_if; driven by mme_controller.
module mme_datapath import mme_pkg::*; #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 16,
	parameter int ADDR_W     = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat,
	input  logic [ADDR_W-1:0]            rd_addr_a,
	input  logic [ADDR_W-1:0]            rd_addr_b,
	input  logic [ROW_W-1:0]             ld_row,
	input  logic [ROW_W-1:0]             ld_col,
	input  logic signed [DATA_WIDTH-1:0] ld_value,
	mme_out_if.source                    out_ch
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic signed [DATA_WIDTH-1:0]   store_a [DEPTH];
	logic signed [DATA_WIDTH-1:0]   store_b [DEPTH];
	logic [ADDR_W-1:0]              wr_addr;

	logic signed [DATA_WIDTH-1:0]   a_rd_s1, b_rd_s1;
	logic                           vld_s1, first_s1, last_s1;
	logic signed [2*DATA_WIDTH-1:0] prod_s2;
	logic                           vld_s2, first_s2, last_s2;

	logic signed [ACC_W-1:0]        acc_q;
	logic                           sum_done_q;
	logic signed [ACC_W-1:0]        p_ext;
	logic [ACC_W:0]                 sum_wide;
	logic signed [ACC_W-1:0]        sum_sat;
	logic signed [PROD_W-1:0]       acc_sat32;

	logic                           out_valid_q;
	logic signed [PROD_W-1:0]       product_q;
	logic [ROW_W-1:0]               out_row_q, out_col_q;
	logic                           last_q, dim_error_q;

	assign wr_addr = ADDR_W'(int'(ld_row) * MAX_DIM + int'(ld_col));

	// loads and reads never share a cycle: loads are taken only while idle
	always_ff @(posedge clk) begin
		if (cmd.ld_a) store_a[wr_addr] <= ld_value;
		if (cmd.ld_b) store_b[wr_addr] <= ld_value;
		if (cmd.rd_en) begin
			a_rd_s1 <= store_a[rd_addr_a];
			b_rd_s1 <= store_b[rd_addr_b];
		end
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_en;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last_k;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// saturating accumulate; the first term of a sum replaces the old total
	assign p_ext    = ACC_W'(prod_s2);
	assign sum_wide = {acc_q[ACC_W-1], acc_q} + {p_ext[ACC_W-1], p_ext};

	always_comb begin
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
			sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			sum_sat = sum_wide[ACC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (vld_s2) acc_q <= first_s2 ? p_ext : sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_done_q <= 1'b0;
		end else if (vld_s2 && last_s2) begin
			sum_done_q <= 1'b1;
		end else if (cmd.emit) begin
			sum_done_q <= 1'b0;
		end
	end

	// fits in 32 bits when the upper bits are all copies of the sign
	always_comb begin
		if (acc_q[ACC_W-1:PROD_W-1] == {(ACC_W-PROD_W+1){acc_q[ACC_W-1]}})
			acc_sat32 = acc_q[PROD_W-1:0];
		else
			acc_sat32 = acc_q[ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			product_q   <= cmd.emit_err ? '0 : acc_sat32;
			out_row_q   <= cmd.emit_row;
			out_col_q   <= cmd.emit_col;
			last_q      <= cmd.emit_last;
			dim_error_q <= cmd.emit_err;
		end
	end

	assign stat.sum_done = sum_done_q;
	assign stat.out_free = !out_valid_q || out_ch.ready;

	assign out_ch.valid     = out_valid_q;
	assign out_ch.product   = product_q;
	assign out_ch.out_row   = out_row_q;
	assign out_ch.out_col   = out_col_q;
	assign out_ch.last      = last_q;
	assign out_ch.dim_error = dim_error_q;

endmodule

[rtl/mme_controller.sv]
// Controller: dimension registers, command decode and the row/col/inner walk.
// Depends on mme_pkg; drives mme_datapath.
module mme_controller import mme_pkg::*; #(
	parameter int MAX_DIM = 8,
	parameter int ADDR_W  = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      in_command,
	input  logic [ROW_W-1:0]      in_row,
	input  logic [ROW_W-1:0]      in_col,
	output dp_cmd_t               cmd,
	input  dp_stat_t              stat,
	output logic [ADDR_W-1:0]     rd_addr_a,
	output logic [ADDR_W-1:0]     rd_addr_b
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ERR,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	state_t                  state_q;
	logic [CFG_DATA_W-1:0]   a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [IDX_W-1:0]        i_q, j_q, k_q;
	logic [CNT_W-1:0]        ar, ac, br, bc;
	logic                    accept, in_range;
	logic                    i_last, j_last, k_last;
	logic [IDX_W+ROW_W-1:0]  i_ext, j_ext;

	function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
		if (d == '0)
			return CNT_W'(1);
		else if (int'(d) > MAX_DIM)
			return CNT_W'(MAX_DIM);
		else
			return CNT_W'(d);
	endfunction

	assign ar = clamp_dim(a_rows_q);
	assign ac = clamp_dim(a_cols_q);
	assign br = clamp_dim(b_rows_q);
	assign bc = clamp_dim(b_cols_q);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

	assign i_last = (CNT_W'(i_q) + CNT_W'(1)) == ar;
	assign j_last = (CNT_W'(j_q) + CNT_W'(1)) == bc;
	assign k_last = (CNT_W'(k_q) + CNT_W'(1)) == ac;

	assign i_ext = {{ROW_W{1'b0}}, i_q};
	assign j_ext = {{ROW_W{1'b0}}, j_q};

	assign rd_addr_a = ADDR_W'(int'(i_q) * MAX_DIM + int'(k_q));
	assign rd_addr_b = ADDR_W'(int'(k_q) * MAX_DIM + int'(j_q));

	always_comb begin
		cmd.ld_a      = accept && (in_command == CMD_LOAD_A) && in_range;
		cmd.ld_b      = accept && (in_command == CMD_LOAD_B) && in_range;
		cmd.rd_en     = (state_q == ST_ISSUE);
		cmd.first     = (k_q == '0);
		cmd.last_k    = k_last;
		cmd.emit      = stat.out_free &&
		                ((state_q == ST_ERR) || ((state_q == ST_WAIT) && stat.sum_done));
		cmd.emit_err  = (state_q == ST_ERR);
		cmd.emit_last = (state_q == ST_ERR) || (i_last && j_last);
		cmd.emit_row  = (state_q == ST_ERR) ? '0 : i_ext[ROW_W-1:0];
		cmd.emit_col  = (state_q == ST_ERR) ? '0 : j_ext[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_rows_q <= DIM_RESET;
			a_cols_q <= DIM_RESET;
			b_rows_q <= DIM_RESET;
			b_cols_q <= DIM_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_A_ROWS: a_rows_q <= cfg_data;
					REG_A_COLS: a_cols_q <= cfg_data;
					REG_B_ROWS: b_rows_q <= cfg_data;
					REG_B_COLS: b_cols_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_command == CMD_MULTIPLY)) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= (ac != br) ? ST_ERR : ST_ISSUE;
					end
				end
				ST_ERR: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				ST_ISSUE: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (stat.sum_done && stat.out_free) begin
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + IDX_W'(1);
								state_q <= ST_ISSUE;
							end
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/mme_checker.sv]
// Port-level assertions for the matrix multiply engine, bound to its top level.
// Depends on mme_pkg and matrix_multiply_engine.
module mme_port_checks import mme_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [CMD_W-1:0]  in_command,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PROD_W-1:0] out_product,
	input logic              out_last
,	input logic              out_dim_error
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_product) && $stable(out_last))
		else $error("result changed while stalled");

	// a multiply item blocks further input while its walk runs
	a_mult_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == CMD_MULTIPLY) |=> !in_ready)
		else $error("input taken right after a multiply item");

	// dimension error is a lone, zero, last result
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_dim_error |-> out_last && (out_product == '0))
		else $error("malformed dimension error result");

	// mid-walk results mean the engine is still busy
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready while a walk is unfinished");

endmodule

bind matrix_multiply_engine mme_port_checks u_mme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_command    (in_ch.command),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_product   (out_ch.product),
	.out_last      (out_ch.last),
	.out_dim_error (out_ch.dim_error)
);
